>>> hw/rtl/hcb_pkg.sv
// Shared constants, types and state encoding of the Huffman code builder.
package hcb_pkg;

  localparam int MAX_SYMBOLS = 32;
  localparam int WEIGHT_BITS = 24;

  localparam int SYMBOL_W = 5;
  localparam int CODE_W   = 31;
  localparam int LEN_W    = 5;

  localparam int NODES    = 2 * MAX_SYMBOLS;
  localparam int NODE_W   = $clog2(NODES);
  localparam int FIFO_AW  = $clog2(MAX_SYMBOLS);
  localparam int SUM_W    = WEIGHT_BITS + $clog2(MAX_SYMBOLS);
  localparam int DEPTH_W  = $clog2(MAX_SYMBOLS);
  localparam int PATH_W   = MAX_SYMBOLS - 1;
  localparam int FIFO_DW  = SUM_W + NODE_W;
  localparam int CHILD_DW = 2 * NODE_W;
  localparam int STACK_DW = NODE_W + DEPTH_W;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_RD1,
    ST_RD2,
    ST_ORD,
    ST_SCAN_RD,
    ST_SCAN,
    ST_JOIN,
    ST_W_INIT,
    ST_W_TEST,
    ST_W_CHILD,
    ST_W_EMIT,
    ST_W_POP
  } state_e;

  typedef struct packed {
    logic load;
    logic start;
    logic rd1;
    logic rd2;
    logic order;
    logic scan_rd;
    logic scan;
    logic join_nodes;
    logic walk_init;
    logic child;
    logic emit;
    logic pop_take;
  } cmd_t;

  typedef struct packed {
    logic n_is_one;
    logic scan_more;
    logic scan_more_next;
    logic last_round;
    logic is_leaf;
    logic stack_empty;
    logic out_free;
  } status_t;

endpackage

>>> hw/rtl/hcb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module hcb_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/hcb_ctrl.sv
// Sequencer of the Huffman code builder: load, merge rounds and tree walk.
module hcb_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_last_i,
  output logic             in_ready_o,
  input  hcb_pkg::status_t status_i,
  output hcb_pkg::cmd_t    cmd_o
);
  import hcb_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && in_last_i) state_d = ST_START;
      end
      ST_START:   state_d = status_i.n_is_one ? ST_W_INIT : ST_RD1;
      ST_RD1:     state_d = ST_RD2;
      ST_RD2:     state_d = ST_ORD;
      ST_ORD:     state_d = status_i.scan_more ? ST_SCAN_RD : ST_JOIN;
      ST_SCAN_RD: state_d = ST_SCAN;
      ST_SCAN:    state_d = status_i.scan_more_next ? ST_SCAN_RD : ST_JOIN;
      ST_JOIN:    state_d = status_i.last_round ? ST_W_INIT : ST_RD1;
      ST_W_INIT:  state_d = ST_W_TEST;
      ST_W_TEST:  state_d = status_i.is_leaf ? ST_W_EMIT : ST_W_CHILD;
      ST_W_CHILD: state_d = ST_W_TEST;
      ST_W_EMIT: begin
        if (status_i.out_free) state_d = status_i.stack_empty ? ST_IDLE : ST_W_POP;
      end
      ST_W_POP:   state_d = ST_W_TEST;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o            = '0;
    in_ready_o       = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_START:   cmd_o.start      = 1'b1;
      ST_RD1:     cmd_o.rd1        = 1'b1;
      ST_RD2:     cmd_o.rd2        = 1'b1;
      ST_ORD:     cmd_o.order      = 1'b1;
      ST_SCAN_RD: cmd_o.scan_rd    = 1'b1;
      ST_SCAN:    cmd_o.scan       = 1'b1;
      ST_JOIN:    cmd_o.join_nodes = 1'b1;
      ST_W_INIT:  cmd_o.walk_init  = 1'b1;
      ST_W_TEST:  ;
      ST_W_CHILD: cmd_o.child      = 1'b1;
      ST_W_EMIT:  cmd_o.emit       = status_i.out_free;
      ST_W_POP:   cmd_o.pop_take   = 1'b1;
      default:    ;
    endcase
  end

endmodule

>>> hw/rtl/hcb_datapath.sv
// Datapath: tree FIFO, child and walk-stack memories, merge and walk registers.
module hcb_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  hcb_pkg::cmd_t                  cmd_i,
  output hcb_pkg::status_t               status_o,
  input  logic [hcb_pkg::WEIGHT_BITS-1:0] weight_i,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic [hcb_pkg::SYMBOL_W-1:0]   symbol_o,
  output logic [hcb_pkg::CODE_W-1:0]     code_bits_o,
  output logic [hcb_pkg::LEN_W-1:0]      code_length_o,
  output logic                           end_of_codes_o
);
  import hcb_pkg::*;

  logic [FIFO_AW-1:0] head_q, head_d, head_inc, tail;
  logic [NODE_W-1:0]  fill_q, fill_d, count_q, count_d, k_q, k_d, j_q, j_d;
  logic [NODE_W-1:0]  round_q, round_d, next_q, next_d;
  logic [SUM_W-1:0]   w1_q, w1_d, w2_q, w2_d;
  logic [NODE_W-1:0]  n1_q, n1_d, n2_q, n2_d;
  logic [NODE_W-1:0]  cur_q, cur_d;
  logic [DEPTH_W-1:0] depth_q, depth_d;
  logic [PATH_W-1:0]  path_q, path_d;
  logic [FIFO_AW-1:0] sp_q, sp_d;
  logic               out_valid_q, out_valid_d, end_q, end_d;
  logic [SYMBOL_W-1:0] sym_q, sym_d;
  logic [CODE_W-1:0]  code_q, code_d;
  logic [LEN_W-1:0]   len_q, len_d;

  logic               fifo_we;
  logic [FIFO_DW-1:0] fifo_wdata, fifo_rdata;
  logic [SUM_W-1:0]   rw;
  logic [NODE_W-1:0]  rn;
  logic               child_we;
  logic [CHILD_DW-1:0] child_rdata;
  logic               stack_we;
  logic [STACK_DW-1:0] stack_wdata, stack_rdata;
  logic [FIFO_AW-1:0] stack_raddr;
  logic [NODE_W:0]    tail_sum;
  logic [DEPTH_W:0]   shamt;

  assign rw = fifo_rdata[FIFO_DW-1:NODE_W];
  assign rn = fifo_rdata[NODE_W-1:0];

  assign head_inc = (head_q == FIFO_AW'(MAX_SYMBOLS - 1)) ? '0 : head_q + 1'b1;
  assign tail_sum = (NODE_W+1)'(head_q) + (NODE_W+1)'(fill_q);
  assign tail = (tail_sum >= (NODE_W+1)'(MAX_SYMBOLS))
              ? FIFO_AW'(tail_sum - (NODE_W+1)'(MAX_SYMBOLS)) : FIFO_AW'(tail_sum);
  assign stack_raddr = sp_q - 1'b1;
  assign shamt = (DEPTH_W+1)'(depth_q) - (DEPTH_W+1)'(stack_rdata[DEPTH_W-1:0])
               + (DEPTH_W+1)'(1);

  always_comb begin
    head_d = head_q;   fill_d = fill_q;   count_d = count_q;
    k_d = k_q;         j_d = j_q;         round_d = round_q;   next_d = next_q;
    w1_d = w1_q;       w2_d = w2_q;       n1_d = n1_q;         n2_d = n2_q;
    cur_d = cur_q;     depth_d = depth_q; path_d = path_q;     sp_d = sp_q;
    sym_d = sym_q;     code_d = code_q;   len_d = len_q;       end_d = end_q;
    out_valid_d = out_valid_q;
    fifo_we = 1'b0;    fifo_wdata = '0;
    child_we = 1'b0;   stack_we = 1'b0;
    stack_wdata = '0;

    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    if (cmd_i.load && (count_q < NODE_W'(MAX_SYMBOLS))) begin
      fifo_we    = 1'b1;
      fifo_wdata = {SUM_W'(weight_i), count_q};
      fill_d     = fill_q + 1'b1;
      count_d    = count_q + 1'b1;
    end
    if (cmd_i.start) begin
      round_d = NODE_W'(1);
      next_d  = count_q;
    end
    if (cmd_i.rd1) begin
      k_d = fill_q;
      j_d = NODE_W'(2);
    end
    if (cmd_i.rd1 || cmd_i.rd2 || cmd_i.scan_rd) begin
      head_d = head_inc;
      fill_d = fill_q - 1'b1;
    end
    if (cmd_i.rd2) begin
      w1_d = rw;
      n1_d = rn;
    end
    if (cmd_i.order) begin
      if (w1_q > rw) begin
        w1_d = rw;   n1_d = rn;
        w2_d = w1_q; n2_d = n1_q;
      end else begin
        w2_d = rw;   n2_d = rn;
      end
    end
    if (cmd_i.scan) begin
      j_d     = j_q + 1'b1;
      fifo_we = 1'b1;
      fill_d  = fill_q + 1'b1;
      if (rw < w2_q) begin
        fifo_wdata = {w2_q, n2_q};
        if (rw < w1_q) begin
          w2_d = w1_q; n2_d = n1_q;
          w1_d = rw;   n1_d = rn;
        end else begin
          w2_d = rw;   n2_d = rn;
        end
      end else begin
        fifo_wdata = {rw, rn};
      end
    end
    if (cmd_i.join_nodes) begin
      child_we   = 1'b1;
      fifo_we    = 1'b1;
      fifo_wdata = {w1_q + w2_q, next_q};
      fill_d     = fill_q + 1'b1;
      next_d     = next_q + 1'b1;
      round_d    = round_q + 1'b1;
    end
    if (cmd_i.walk_init) begin
      cur_d   = next_q - 1'b1;
      depth_d = '0;
      path_d  = '0;
      sp_d    = '0;
    end
    if (cmd_i.child) begin
      stack_we    = 1'b1;
      stack_wdata = {child_rdata[NODE_W-1:0], depth_q + 1'b1};
      sp_d        = sp_q + 1'b1;
      cur_d       = child_rdata[CHILD_DW-1:NODE_W];
      depth_d     = depth_q + 1'b1;
      path_d      = path_q << 1;
    end
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      sym_d  = SYMBOL_W'(cur_q);
      code_d = CODE_W'(path_q);
      len_d  = LEN_W'(depth_q);
      end_d  = (sp_q == '0);
      if (sp_q == '0) begin
        // Run complete: return to an empty set for the next load.
        count_d = '0;
        head_d  = '0;
        fill_d  = '0;
      end else begin
        sp_d = sp_q - 1'b1;
      end
    end
    if (cmd_i.pop_take) begin
      // Keep the prefix above the pending right child, then take its 1 branch.
      path_d  = ((path_q >> shamt) << 1) | PATH_W'(1);
      depth_d = stack_rdata[DEPTH_W-1:0];
      cur_d   = stack_rdata[STACK_DW-1:DEPTH_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      fill_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      fill_q      <= fill_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q <= k_d;       j_q <= j_d;       round_q <= round_d;   next_q <= next_d;
    w1_q <= w1_d;     w2_q <= w2_d;     n1_q <= n1_d;         n2_q <= n2_d;
    cur_q <= cur_d;   depth_q <= depth_d; path_q <= path_d;   sp_q <= sp_d;
    sym_q <= sym_d;   code_q <= code_d; len_q <= len_d;       end_q <= end_d;
  end

  hcb_ram #(.Width(FIFO_DW), .Depth(MAX_SYMBOLS)) u_fifo_ram (
    .clk_i   (clk_i),
    .we_i    (fifo_we),
    .waddr_i (tail),
    .wdata_i (fifo_wdata),
    .raddr_i (head_q),
    .rdata_o (fifo_rdata)
  );

  hcb_ram #(.Width(CHILD_DW), .Depth(NODES)) u_child_ram (
    .clk_i   (clk_i),
    .we_i    (child_we),
    .waddr_i (next_q),
    .wdata_i ({n1_q, n2_q}),
    .raddr_i (cur_q),
    .rdata_o (child_rdata)
  );

  hcb_ram #(.Width(STACK_DW), .Depth(MAX_SYMBOLS)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stack_we),
    .waddr_i (sp_q),
    .wdata_i (stack_wdata),
    .raddr_i (stack_raddr),
    .rdata_o (stack_rdata)
  );

  assign status_o.n_is_one       = (count_q == NODE_W'(1));
  assign status_o.scan_more      = (j_q < k_q);
  assign status_o.scan_more_next = ((j_q + 1'b1) < k_q);
  assign status_o.last_round     = ((round_q + 1'b1) == count_q);
  assign status_o.is_leaf        = (cur_q < count_q);
  assign status_o.stack_empty    = (sp_q == '0);
  assign status_o.out_free       = !out_valid_q || out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign symbol_o       = sym_q;
  assign code_bits_o    = code_q;
  assign code_length_o  = len_q;
  assign end_of_codes_o = end_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= NODE_W'(MAX_SYMBOLS))
    else $error("tree FIFO fill exceeds its depth");

  a_emit_leaf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (cur_q < count_q))
    else $error("walk emits a code for an internal node");

  a_run_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && (sp_q == '0)) |=> (count_q == '0) && (fill_q == '0))
    else $error("symbol set not cleared after the last code");

endmodule

>>> hw/rtl/huffman_code_builder.sv
// Weight beats are taken while the block is idle; after the beat with last high the n-1
// merge rounds each rotate the whole tree FIFO through its single read port. The walk
// then descends to first children, pushing each second child, emits a code at each leaf
// and pops the next pending child from the walk stack.
// Throughput: one symbol set at a time; new weights are taken once the last code is issued.
// Reset (rst_ni, asynchronous, active low) empties the symbol set and the output register.
module huffman_code_builder (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [hcb_pkg::WEIGHT_BITS-1:0] weight_i,
  input  logic                            last_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [hcb_pkg::SYMBOL_W-1:0]    symbol_o,
  output logic [hcb_pkg::CODE_W-1:0]      code_bits_o,
  output logic [hcb_pkg::LEN_W-1:0]       code_length_o,
  output logic                            end_of_codes_o
);
  import hcb_pkg::*;

  // The controller steps through load, merge and walk; the datapath holds all storage.
  cmd_t    cmd;
  status_t status;

  hcb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (last_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Each result beat sits in an output register, so the walk only waits when a
  // previous code is still unclaimed.
  hcb_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .weight_i       (weight_i),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .symbol_o       (symbol_o),
    .code_bits_o    (code_bits_o),
    .code_length_o  (code_length_o),
    .end_of_codes_o (end_of_codes_o)
  );

endmodule
